@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ design/gks_pkg.sv @@
// ---------------------------------------------------------------------------
// gks_pkg
// Shared types, codes and helpers for the grid Kruskal set merger.
// ---------------------------------------------------------------------------
package gks_pkg;

    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 32;

    // Width of a clamped grid dimension (values up to 63).
    localparam int DIM_W = 9;
    localparam int CFG_W = 6;
    localparam int SETS_W = 11;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 6'd32;

    localparam logic [1:0] STATUS_CARVED  = 2'd0;
    localparam logic [1:0] STATUS_KEPT    = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd2;
    localparam logic [1:0] STATUS_START   = 2'd3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_EDGE  = 1'b1;

    localparam logic DIR_SOUTH = 1'b0;
    localparam logic DIR_EAST  = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD_THERE,
        ST_CMP,
        ST_SCAN
    } t_state;

    // Zero reads as one, anything above the limit reads as the limit.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int hi);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > hi) begin
            res = DIM_W'(hi);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

endpackage

@@ design/grid_kruskal_set_merger.sv @@
// ---------------------------------------------------------------------------
// grid_kruskal_set_merger
// Union-find by relabelling over a grid of cells, for Kruskal maze carving.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; each item yields one
// result, shown for a single cycle with o_valid, which the receiver must take.
// All set labels live in one single-port-read, single-port-write memory of
// MAX_ROWS*MAX_COLS entries; every long operation walks it one entry a cycle.
// After reset the block runs a pass that writes every entry its own index, with
// busy high (register writes are still taken). An edge outside the grid is
// answered straight from idle; an edge in one set after both labels are read;
// a carved edge after a relabel scan of the store; a start after a label
// rewrite of the store. busy drops in the cycle the result is shown.
// ---------------------------------------------------------------------------
module grid_kruskal_set_merger #(
    parameter int MAX_ROWS = gks_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gks_pkg::DEF_MAX_COLS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_op,
    input  logic [4:0]                 i_cell_row,
    input  logic [4:0]                 i_cell_col,
    input  logic                       i_direction,
    output logic                       o_valid,
    output logic [1:0]                 o_status,
    output logic [4:0]                 o_echo_row,
    output logic [4:0]                 o_echo_col,
    output logic                       o_echo_direction,
    output logic [gks_pkg::SETS_W-1:0] o_sets_left
);
    import gks_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int LW = $clog2(CELLS);

    logic [CFG_W-1:0] w_rows, w_cols;
    logic             w_rd_en, w_wr_en;
    logic [LW-1:0]    w_rd_addr, w_rd_data, w_wr_addr, w_wr_data;

    gks_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_rows_in_use (w_rows),
        .o_cols_in_use (w_cols)
    );

    gks_label_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (LW),
        .DATA_W (LW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    gks_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_cell_row       (i_cell_row),
        .i_cell_col       (i_cell_col),
        .i_direction      (i_direction),
        .i_rows_in_use    (w_rows),
        .i_cols_in_use    (w_cols),
        .o_rd_en          (w_rd_en),
        .o_rd_addr        (w_rd_addr),
        .i_rd_data        (w_rd_data),
        .o_wr_en          (w_wr_en),
        .o_wr_addr        (w_wr_addr),
        .o_wr_data        (w_wr_data),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_echo_row       (o_echo_row),
        .o_echo_col       (o_echo_col),
        .o_echo_direction (o_echo_direction),
        .o_sets_left      (o_sets_left)
    );

endmodule

@@ design/gks_label_ram.sv @@
// ---------------------------------------------------------------------------
// gks_label_ram
// Set label store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module gks_label_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 10
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/gks_apb_regs.sv @@
// ---------------------------------------------------------------------------
// gks_apb_regs
// APB register file holding the grid size in use.
// ---------------------------------------------------------------------------
module gks_apb_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic [gks_pkg::CFG_W-1:0] o_rows_in_use,
    output logic [gks_pkg::CFG_W-1:0] o_cols_in_use
);
    import gks_pkg::*;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    logic [CFG_W-1:0] r_rows;
    logic [CFG_W-1:0] r_cols;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_DIM_RESET;
            r_cols <= CFG_DIM_RESET;
        end else if (w_wr) begin
            if (paddr[2] == REG_ROWS) begin
                r_rows <= pwdata[CFG_W-1:0];
            end else begin
                r_cols <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ROWS: prdata = 32'(r_rows);
            REG_COLS: prdata = 32'(r_cols);
            default:  prdata = '0;
        endcase
    end

    assign o_rows_in_use = r_rows;
    assign o_cols_in_use = r_cols;

endmodule

@@ design/gks_ctrl.sv @@
// ---------------------------------------------------------------------------
// gks_ctrl
// Sequencer: label store init sweep, edge lookup and relabel scan.
// ---------------------------------------------------------------------------
module gks_ctrl #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32,
    localparam int CELLS = MAX_ROWS * MAX_COLS,
    localparam int LW = $clog2(CELLS),
    localparam int SW = $clog2(CELLS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_op,
    input  logic [4:0]                 i_cell_row,
    input  logic [4:0]                 i_cell_col,
    input  logic                       i_direction,
    input  logic [gks_pkg::CFG_W-1:0]  i_rows_in_use,
    input  logic [gks_pkg::CFG_W-1:0]  i_cols_in_use,
    output logic                       o_rd_en,
    output logic [LW-1:0]              o_rd_addr,
    input  logic [LW-1:0]              i_rd_data,
    output logic                       o_wr_en,
    output logic [LW-1:0]              o_wr_addr,
    output logic [LW-1:0]              o_wr_data,
    output logic                       o_valid,
    output logic [1:0]                 o_status,
    output logic [4:0]                 o_echo_row,
    output logic [4:0]                 o_echo_col,
    output logic                       o_echo_direction,
    output logic [gks_pkg::SETS_W-1:0] o_sets_left
);
    import gks_pkg::*;

    localparam int RST_ROWS = (MAX_ROWS < 32) ? MAX_ROWS : 32;
    localparam int RST_COLS = (MAX_COLS < 32) ? MAX_COLS : 32;
    localparam int SWX = (SW > SETS_W) ? SW : SETS_W;
    localparam logic [LW-1:0] LAST_IDX = LW'(CELLS - 1);

    t_state r_state, n_state;
    logic [LW-1:0] r_idx, n_idx;
    logic          r_valid, n_valid;
    logic          r_start_pending, n_start_pending;
    logic [SW-1:0] r_set_count, n_set_count;

    logic [LW-1:0] r_there, n_there;
    logic [LW-1:0] r_winner, n_winner;
    logic [LW-1:0] r_loser, n_loser;
    logic [1:0]    r_status, n_status;
    logic [4:0]    r_row, n_row;
    logic [4:0]    r_col, n_col;
    logic          r_dir, n_dir;

    logic [DIM_W-1:0] w_nrows, w_ncols;
    logic [DIM_W-1:0] w_r, w_c;
    logic             w_accept, w_outside, w_last;
    logic [LW-1:0]    w_here, w_there;
    logic [SWX-1:0]   w_sets_ext;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_last   = (r_idx == LAST_IDX);

    assign w_nrows = clamp_dim(i_rows_in_use, MAX_ROWS);
    assign w_ncols = clamp_dim(i_cols_in_use, MAX_COLS);
    assign w_r     = DIM_W'(i_cell_row);
    assign w_c     = DIM_W'(i_cell_col);

    assign w_outside = (w_r >= w_nrows) || (w_c >= w_ncols)
                    || ((i_direction == DIR_SOUTH) && (w_r + DIM_W'(1) >= w_nrows))
                    || ((i_direction == DIR_EAST)  && (w_c + DIM_W'(1) >= w_ncols));

    assign w_here  = LW'(32'(i_cell_row) * MAX_COLS + 32'(i_cell_col));
    assign w_there = (i_direction == DIR_SOUTH) ? w_here + LW'(MAX_COLS) : w_here + LW'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (w_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    priority if (i_op == OP_START) begin
                        n_state = ST_INIT;
                    end else if (w_outside) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_RD_THERE;
                    end
                end
            end
            ST_RD_THERE: n_state = ST_CMP;
            ST_CMP: begin
                n_state = (i_rd_data == r_winner) ? ST_IDLE : ST_SCAN;
            end
            ST_SCAN: begin
                if (w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_idx           = r_idx;
        n_valid         = 1'b0;
        n_start_pending = r_start_pending;
        n_set_count     = r_set_count;
        n_there         = r_there;
        n_winner        = r_winner;
        n_loser         = r_loser;
        n_status        = r_status;
        n_row           = r_row;
        n_col           = r_col;
        n_dir           = r_dir;
        o_rd_en         = 1'b0;
        o_rd_addr       = r_there;
        o_wr_en         = 1'b0;
        o_wr_addr       = r_idx;
        o_wr_data       = r_idx;
        unique case (r_state)
            ST_INIT: begin
                o_wr_en = 1'b1;
                if (w_last) begin
                    n_valid         = r_start_pending;
                    n_start_pending = 1'b0;
                end else begin
                    n_idx = r_idx + LW'(1);
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_START) begin
                        n_row           = '0;
                        n_col           = '0;
                        n_dir           = 1'b0;
                        n_status        = STATUS_START;
                        n_set_count     = SW'(w_nrows) * SW'(w_ncols);
                        n_start_pending = 1'b1;
                        n_idx           = '0;
                    end else begin
                        n_row = i_cell_row;
                        n_col = i_cell_col;
                        n_dir = i_direction;
                        if (w_outside) begin
                            n_status = STATUS_OUTSIDE;
                            n_valid  = 1'b1;
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = w_here;
                            n_there   = w_there;
                        end
                    end
                end
            end
            ST_RD_THERE: begin
                n_winner  = i_rd_data;
                o_rd_en   = 1'b1;
                o_rd_addr = r_there;
            end
            ST_CMP: begin
                n_loser = i_rd_data;
                if (i_rd_data == r_winner) begin
                    n_status = STATUS_KEPT;
                    n_valid  = 1'b1;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = '0;
                    n_idx     = '0;
                end
            end
            ST_SCAN: begin
                // read of the next entry overlaps the write-back of this one
                o_wr_en   = (i_rd_data == r_loser);
                o_wr_data = r_winner;
                if (w_last) begin
                    if (r_set_count != '0) begin
                        n_set_count = r_set_count - SW'(1);
                    end
                    n_status = STATUS_CARVED;
                    n_valid  = 1'b1;
                end else begin
                    n_idx     = r_idx + LW'(1);
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_idx + LW'(1);
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_INIT;
            r_idx           <= '0;
            r_valid         <= 1'b0;
            r_start_pending <= 1'b0;
            r_set_count     <= SW'(RST_ROWS * RST_COLS);
        end else begin
            r_state         <= n_state;
            r_idx           <= n_idx;
            r_valid         <= n_valid;
            r_start_pending <= n_start_pending;
            r_set_count     <= n_set_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_there  <= n_there;
        r_winner <= n_winner;
        r_loser  <= n_loser;
        r_status <= n_status;
        r_row    <= n_row;
        r_col    <= n_col;
        r_dir    <= n_dir;
    end

    assign w_sets_ext       = SWX'(r_set_count);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_echo_row       = r_row;
    assign o_echo_col       = r_col;
    assign o_echo_direction = r_dir;
    assign o_sets_left      = w_sets_ext[SETS_W-1:0];

endmodule

@@ design/gks_checker.sv @@
// ---------------------------------------------------------------------------
// gks_checker
// Port-level checks on the grid Kruskal set merger, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gks_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_valid,
    input logic [1:0]                 o_status,
    input logic [4:0]                 o_echo_row,
    input logic [4:0]                 o_echo_col,
    input logic                       o_echo_direction,
    input logic [gks_pkg::SETS_W-1:0] o_sets_left
);
    import gks_pkg::*;

    // every transfer in is followed by either work in progress or its result
    `ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_valid)

    `ASSERT_IMPLY(a_result_idle, i_clk, i_rst_n, o_valid, !busy)

    `ASSERT_IMPLY(a_start_echo_zero, i_clk, i_rst_n, o_valid && (o_status == STATUS_START), (o_echo_row == '0) && (o_echo_col == '0) && !o_echo_direction)

    // no merge, no change in the set count
    `ASSERT_IMPLY(a_count_kept, i_clk, i_rst_n, o_valid && ((o_status == STATUS_KEPT) || (o_status == STATUS_OUTSIDE)), $stable(o_sets_left))

endmodule

bind grid_kruskal_set_merger gks_checker u_gks_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_status         (o_status),
    .o_echo_row       (o_echo_row),
    .o_echo_col       (o_echo_col),
    .o_echo_direction (o_echo_direction),
    .o_sets_left      (o_sets_left)
);
